### rtl/scope_frame_crc16_framer_unit_defines.svh
// assertion macros for the scope frame crc16 framer checker
// depends on nothing; included by the checker file only
`ifndef SCOPE_FRAME_CRC16_FRAMER_UNIT_DEFINES_SVH
`define SCOPE_FRAME_CRC16_FRAMER_UNIT_DEFINES_SVH

// antecedent implies consequent in the next cycle
`define SCFR_ASSERT_NEXT(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SCFR_ASSERT_NOW(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

`endif

### rtl/scfr_pkg.sv
// shared types, constants and crc helper for the scope frame crc16 framer
// depends on nothing
package scfr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 4;

    localparam logic [IDX_W-1:0] DATA_BYTES = 4'd8;
    localparam logic [IDX_W-1:0] CRC_LO_IDX = 4'd8;
    localparam logic [IDX_W-1:0] LAST_IDX   = 4'd9;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // sample_a sits in the low bits so bytes go out low first in channel order
    typedef struct packed {
        logic [SAMPLE_W-1:0] smp_d;
        logic [SAMPLE_W-1:0] smp_c;
        logic [SAMPLE_W-1:0] smp_b;
        logic [SAMPLE_W-1:0] smp_a;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } qhead_t;

    // one byte of reflected crc16, eight shift steps
    function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [BYTE_W-1:0] data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

### rtl/scope_frame_crc16_framer_unit.sv
// Four signed 16-bit samples in, a ten-byte frame out: the samples low byte first in
// channel order, then the CRC-16/MODBUS of those eight bytes, low byte first, with
// is_last on the tenth byte. The one-byte output port paces the frame; a request
// goes into the queue first, then its first byte into the output register. A queue of
// QUEUE_DEPTH frames sits in front of the serializer, so the next request is taken while
// a frame is still going out, and frames follow each other with no gap.
// depends on scfr_pkg, scfr_frame_queue, scfr_byte_serializer
module scope_frame_crc16_framer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample_a,
    input  logic signed [15:0] sample_b,
    input  logic signed [15:0] sample_c,
    input  logic signed [15:0] sample_d,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_byte,
    output logic               is_last
);
    import scfr_pkg::*;

    frame_t in_frame;
    qhead_t head;
    logic   pop;

    assign in_frame.smp_a = sample_a;
    assign in_frame.smp_b = sample_b;
    assign in_frame.smp_c = sample_c;
    assign in_frame.smp_d = sample_d;

    scfr_frame_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(in_valid),
        .push_ready(in_ready),
        .push_frame(in_frame),
        .head      (head),
        .pop       (pop)
    );

    scfr_byte_serializer u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_byte(frame_byte),
        .is_last   (is_last)
    );

endmodule

### rtl/scfr_frame_queue.sv
// front end: takes sample requests and holds them in a short frame queue
// depends on scfr_pkg
module scfr_frame_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  scfr_pkg::frame_t push_frame,
    output scfr_pkg::qhead_t head,
    input  logic            pop
);
    import scfr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.frame = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_frame;
        end
    end

endmodule

### rtl/scfr_byte_serializer.sv
// back end: walks the head frame one byte per cycle while the output is not stalled, runs the crc, appends it
// depends on scfr_pkg
module scfr_byte_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  scfr_pkg::qhead_t            head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [scfr_pkg::BYTE_W-1:0] frame_byte,
    output logic                        is_last
);
    import scfr_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]       crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              adv;
    logic              emit;
    logic              is_data;
    logic [63:0]       head_bits;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] cur_byte;

    assign head_bits = head.frame;
    assign adv       = !out_valid_reg || out_ready;
    assign emit      = adv && head.valid;
    assign is_data   = (idx_reg < DATA_BYTES);
    assign data_byte = head_bits[{idx_reg[2:0], 3'b000} +: BYTE_W];
    assign pop       = emit && (idx_reg == LAST_IDX);

    always_comb
    begin
        priority if (is_data)
        begin
            cur_byte = data_byte;
        end
        else if (idx_reg == CRC_LO_IDX)
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = crc_reg[15:8];
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = head.valid;
        end
        if (emit)
        begin
            if (idx_reg == LAST_IDX)
            begin
                idx_next = '0;
                crc_next = CRC_SEED;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (is_data)
                begin
                    crc_next = crc16_byte(crc_reg, data_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= CRC_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= cur_byte;
            last_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign is_last    = last_reg;

endmodule

### rtl/scfr_checker.sv
// port-level checks on the scope frame crc16 framer, bound to the top level
// depends on scope_frame_crc16_framer_unit_defines.svh
`include "scope_frame_crc16_framer_unit_defines.svh"

module scfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       is_last
);

    // stalled output holds
    `SCFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(is_last), "output changed while stalled")

    // bytes of one frame go out with no gap
    `SCFR_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && out_ready && !is_last, out_valid, "gap inside a frame")

    // two last bytes never follow each other
    `SCFR_ASSERT_NEXT(a_last_single, clk, rst_n, out_valid && out_ready && is_last, !(out_valid && is_last), "back to back last flags")

    // a waiting request meets a full queue only while a frame is going out
    `SCFR_ASSERT_NOW(a_ready_known, clk, rst_n, in_valid, in_ready || out_valid, "queue full with nothing going out")

endmodule

bind scope_frame_crc16_framer_unit scfr_checker u_scfr_checker (.*);
